// ===== rtl/core/calendar_date_counter_unit_macros.svh =====
// Assertion macros used by the checker of the date counter.
`ifndef CALENDAR_DATE_COUNTER_UNIT_MACROS_SVH
`define CALENDAR_DATE_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define CDCU_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("date counter check failed");

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define CDCU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("date counter check failed");

`endif

// ===== rtl/core/cdcu_pkg.sv =====
package cdcu_pkg;

    typedef struct packed {
        logic        func;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [11:0] set_year;
        logic [15:0] day_count;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  cur_month;
        logic [4:0]  cur_day;
        logic [11:0] cur_year;
        logic [2:0]  status;
    } t_out_item;

    localparam logic        FUNC_SET = 1'b0;
    localparam logic        FUNC_ADV = 1'b1;

    localparam logic [2:0]  ST_OK        = 3'd0;
    localparam logic [2:0]  ST_BAD_MONTH = 3'd1;
    localparam logic [2:0]  ST_BAD_YEAR  = 3'd2;
    localparam logic [2:0]  ST_BAD_DAY   = 3'd3;
    localparam logic [2:0]  ST_OVERFLOW  = 3'd4;

    localparam logic [3:0]  MONTH_JAN  = 4'd1;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [11:0] YEAR_MIN   = 12'd1900;
    localparam logic [11:0] YEAR_MAX   = 12'd2100;
    localparam logic [11:0] YEAR_LIMIT = 12'd4095;

    // True when v is a multiple of 25; v stays below 1024, so 41 compares cover it.
    function automatic logic is_mult25(input logic [9:0] v);
        logic r;
        r = 1'b0;
        for (int k = 0; k <= 40; k++) begin
            if (v == 10'(k * 25)) begin
                r = 1'b1;
            end
        end
        return r;
    endfunction

    // Divisible by 100 means divisible by 4 with a quotient that is a multiple
    // of 25; divisible by 400 means divisible by 16 with the same property.
    function automatic logic is_leap(input logic [11:0] y);
        logic div4;
        logic div100;
        logic div400;
        div4   = (y[1:0] == 2'b00);
        div100 = div4 && is_mult25(y[11:2]);
        div400 = (y[3:0] == 4'b0000) && is_mult25({2'b00, y[11:4]});
        return div400 || (div4 && !div100);
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd2:                      r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   r = 5'd30;
            default:                   r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/cdcu_if.sv =====
interface cdcu_in_if import cdcu_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cdcu_out_if import cdcu_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/calendar_date_counter_unit.sv =====
// A set item is checked and loaded into the date as it transfers; an advance by n days
// steps the date a day at a time, stopping early when the year overflows. The result
// goes to the output register once the steps are done. One item at a time: the input
// stays closed from a transfer until its result has entered the output register.
// A result held in the output register stalls the sequencer until it is taken.
// Reset (synchronous, active low) returns the date to January 1, 1900 and empties
// the output register.
module calendar_date_counter_unit import cdcu_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdcu_in_if.sink     i_in,
    cdcu_out_if.source  o_out
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic        r_state,   n_state;
    logic [3:0]  r_month,   n_month;
    logic [4:0]  r_day,     n_day;
    logic [11:0] r_year,    n_year;
    logic [15:0] r_remain,  n_remain;
    logic [2:0]  r_status,  n_status;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out,     n_out;

    logic [4:0]  cur_len;
    logic [4:0]  set_len;
    logic        in_xfer;

    assign i_in.ready   = (r_state == S_IDLE);
    assign in_xfer      = i_in.valid && i_in.ready;
    assign o_out.valid  = r_out_valid;
    assign o_out.data   = r_out;

    assign cur_len = days_in(r_month, is_leap(r_year));
    assign set_len = days_in(i_in.data.set_month, is_leap(i_in.data.set_year));

    always_comb begin
        n_state     = r_state;
        n_month     = r_month;
        n_day       = r_day;
        n_year      = r_year;
        n_remain    = r_remain;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state  = S_RUN;
                    n_status = ST_OK;
                    n_remain = '0;
                    if (i_in.data.func == FUNC_ADV) begin
                        n_remain = i_in.data.day_count;
                    end else if (i_in.data.set_month < MONTH_JAN ||
                                 i_in.data.set_month > MONTH_DEC) begin
                        n_status = ST_BAD_MONTH;
                    end else if (i_in.data.set_year < YEAR_MIN ||
                                 i_in.data.set_year > YEAR_MAX) begin
                        n_status = ST_BAD_YEAR;
                    end else if (i_in.data.set_day == 5'd0 ||
                                 i_in.data.set_day > set_len) begin
                        n_status = ST_BAD_DAY;
                    end else begin
                        n_month = i_in.data.set_month;
                        n_day   = i_in.data.set_day;
                        n_year  = i_in.data.set_year;
                    end
                end
            end
            S_RUN: begin
                if (r_remain == '0) begin
                    // The result may only go out once the previous one has left.
                    if (!r_out_valid || o_out.ready) begin
                        n_out_valid     = 1'b1;
                        n_out.cur_month = r_month;
                        n_out.cur_day   = r_day;
                        n_out.cur_year  = r_year;
                        n_out.status    = r_status;
                        n_state         = S_IDLE;
                    end
                end else begin
                    n_remain = r_remain - 16'd1;
                    if (r_day < cur_len) begin
                        n_day = r_day + 5'd1;
                    end else if (r_month < MONTH_DEC) begin
                        n_month = r_month + 4'd1;
                        n_day   = 5'd1;
                    end else if (r_year >= YEAR_LIMIT) begin
                        // The date stays on the last day; remaining days are dropped.
                        n_status = ST_OVERFLOW;
                        n_remain = '0;
                    end else begin
                        n_year  = r_year + 12'd1;
                        n_month = MONTH_JAN;
                        n_day   = 5'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_month     <= MONTH_JAN;
            r_day       <= 5'd1;
            r_year      <= YEAR_MIN;
            r_remain    <= '0;
            r_status    <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_month     <= n_month;
            r_day       <= n_day;
            r_year      <= n_year;
            r_remain    <= n_remain;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ===== rtl/core/cdcu_checker.sv =====
`include "calendar_date_counter_unit_macros.svh"

module cdcu_checker import cdcu_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_cur_month,
    input logic [4:0]  i_cur_day,
    input logic [11:0] i_cur_year,
    input logic [2:0]  i_status
);

    // A stalled result keeps its payload until the transfer.
    `CDCU_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_cur_month) && $stable(i_cur_day) && $stable(i_cur_year) && $stable(i_status))

    // One item at a time: the input side closes after each transfer.
    `CDCU_ASSERT_NEXT(a_busy_after_xfer, i_in_valid && i_in_ready, !i_in_ready)

    // Every result carries a real date and a defined status.
    `CDCU_ASSERT_SAME(a_date_range, i_out_valid, i_cur_month >= MONTH_JAN && i_cur_month <= MONTH_DEC && i_cur_day != 5'd0 && i_cur_year >= YEAR_MIN && i_status <= ST_OVERFLOW)

    // Overflow only ever leaves the date on the last day of the last year.
    `CDCU_ASSERT_SAME(a_overflow_date, i_out_valid && i_status == ST_OVERFLOW, i_cur_year == YEAR_LIMIT && i_cur_month == MONTH_DEC && i_cur_day == 5'd31)

endmodule

bind calendar_date_counter_unit cdcu_checker u_cdcu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_cur_month (o_out.data.cur_month),
    .i_cur_day   (o_out.data.cur_day),
    .i_cur_year  (o_out.data.cur_year),
    .i_status    (o_out.data.status)
);

// ===== tb/tb_calendar_date_counter_unit.sv =====
module tb_calendar_date_counter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cdcu_pkg::*;

    typedef struct {
        logic        func;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [11:0] year;
        logic [15:0] count;
        int          reps;
        bit          typed;
        t_out_item   want;
    } t_date_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cdcu_in_if  in_ch ();
    cdcu_out_if out_ch ();

    calendar_date_counter_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Shadow copy of the stored date.
    int cal_month = 1;
    int cal_day   = 1;
    int cal_year  = 1900;

    t_out_item date_expect_q[$];
    int        err_count    = 0;
    int        in_idle_pct  = 11;
    int        out_idle_pct = 64;

    // Rows with a typed result are checked against that value; the others use the predictor.
    t_date_row date_rows[25] = '{
        '{FUNC_ADV, 4'd0,  5'd0,  12'd0,    16'd0,      1, 1, {4'd1, 5'd1, 12'd1900, ST_OK}},
        '{FUNC_SET, 4'd0,  5'd1,  12'd2000, 16'd0,      1, 1, {4'd1, 5'd1, 12'd1900, ST_BAD_MONTH}},
        '{FUNC_SET, 4'd15, 5'd0,  12'd0,    16'hFFFF,   1, 1, {4'd1, 5'd1, 12'd1900, ST_BAD_MONTH}},
        '{FUNC_SET, 4'd13, 5'd15, 12'd2000, 16'd0,      1, 1, {4'd1, 5'd1, 12'd1900, ST_BAD_MONTH}},
        '{FUNC_SET, 4'd6,  5'd0,  12'd1899, 16'd0,      1, 1, {4'd1, 5'd1, 12'd1900, ST_BAD_YEAR}},
        '{FUNC_SET, 4'd12, 5'd31, 12'd4095, 16'd0,      1, 1, {4'd1, 5'd1, 12'd1900, ST_BAD_YEAR}},
        '{FUNC_SET, 4'd2,  5'd29, 12'd1900, 16'd0,      1, 1, {4'd1, 5'd1, 12'd1900, ST_BAD_DAY}},
        '{FUNC_SET, 4'd2,  5'd29, 12'd2000, 16'd0,      1, 1, {4'd2, 5'd29, 12'd2000, ST_OK}},
        '{FUNC_SET, 4'd2,  5'd30, 12'd2000, 16'd0,      1, 1, {4'd2, 5'd29, 12'd2000, ST_BAD_DAY}},
        '{FUNC_SET, 4'd4,  5'd31, 12'd2004, 16'd0,      1, 1, {4'd2, 5'd29, 12'd2000, ST_BAD_DAY}},
        '{FUNC_SET, 4'd1,  5'd0,  12'd2000, 16'd0,      1, 1, {4'd2, 5'd29, 12'd2000, ST_BAD_DAY}},
        '{FUNC_SET, 4'd2,  5'd29, 12'd2100, 16'd0,      1, 1, {4'd2, 5'd29, 12'd2000, ST_BAD_DAY}},
        '{FUNC_SET, 4'd2,  5'd28, 12'd2100, 16'd0,      1, 1, {4'd2, 5'd28, 12'd2100, ST_OK}},
        '{FUNC_ADV, 4'd0,  5'd0,  12'd0,    16'd1,      1, 0, '0},
        '{FUNC_SET, 4'd12, 5'd31, 12'd1999, 16'd0,      1, 1, {4'd12, 5'd31, 12'd1999, ST_OK}},
        '{FUNC_ADV, 4'd0,  5'd0,  12'd0,    16'd1,      1, 0, '0},
        '{FUNC_SET, 4'd2,  5'd28, 12'd2024, 16'd0,      1, 1, {4'd2, 5'd28, 12'd2024, ST_OK}},
        '{FUNC_ADV, 4'd0,  5'd0,  12'd0,    16'd2,      1, 0, '0},
        '{FUNC_SET, 4'd1,  5'd1,  12'd1900, 16'd0,      1, 1, {4'd1, 5'd1, 12'd1900, ST_OK}},
        '{FUNC_ADV, 4'd15, 5'd31, 12'd4095, 16'd0,      1, 1, {4'd1, 5'd1, 12'd1900, ST_OK}},
        '{FUNC_SET, 4'd12, 5'd31, 12'd2100, 16'd0,      1, 1, {4'd12, 5'd31, 12'd2100, ST_OK}},
        // Twelve full-length advances carry the date to the last day of year 4095, where it overflows.
        '{FUNC_ADV, 4'd0,  5'd0,  12'd0,    16'hFFFF,  12, 0, '0},
        '{FUNC_ADV, 4'd0,  5'd0,  12'd0,    16'd1,      1, 1, {4'd12, 5'd31, 12'd4095, ST_OVERFLOW}},
        '{FUNC_ADV, 4'd0,  5'd0,  12'd0,    16'd0,      1, 1, {4'd12, 5'd31, 12'd4095, ST_OK}},
        '{FUNC_SET, 4'd3,  5'd15, 12'd2050, 16'd0,      1, 1, {4'd3, 5'd15, 12'd2050, ST_OK}}
    };

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        out_ch.ready = 1'b0;
    end

    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic bit leap_year(input int y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int month_days(input int m, input int y);
        if (m == MONTH_FEB) begin
            return leap_year(y) ? 29 : 28;
        end
        case (m)
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Applies one item to the shadow date and returns the result it should produce.
    function automatic t_out_item predict_date(input t_in_item it);
        t_out_item r;
        int        k;
        r.status = ST_OK;
        if (it.func == FUNC_SET) begin
            if (it.set_month < MONTH_JAN || it.set_month > MONTH_DEC) begin
                r.status = ST_BAD_MONTH;
            end else if (it.set_year < YEAR_MIN || it.set_year > YEAR_MAX) begin
                r.status = ST_BAD_YEAR;
            end else if (it.set_day < 1 || it.set_day > month_days(it.set_month, it.set_year)) begin
                r.status = ST_BAD_DAY;
            end else begin
                cal_month = it.set_month;
                cal_day   = it.set_day;
                cal_year  = it.set_year;
            end
        end else begin
            for (k = 0; k < it.day_count; k++) begin
                if (cal_day < month_days(cal_month, cal_year)) begin
                    cal_day++;
                end else if (cal_month < MONTH_DEC) begin
                    cal_month++;
                    cal_day = 1;
                end else if (cal_year >= YEAR_LIMIT) begin
                    r.status = ST_OVERFLOW;
                    break;
                end else begin
                    cal_year++;
                    cal_month = MONTH_JAN;
                    cal_day   = 1;
                end
            end
        end
        r.cur_month = 4'(cal_month);
        r.cur_day   = 5'(cal_day);
        r.cur_year  = 12'(cal_year);
        return r;
    endfunction

    // Mostly plausible dates, often at a month end, so that advances roll over.
    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        it.func      = 1'($urandom);
        it.set_month = 4'($urandom);
        it.set_day   = 5'($urandom);
        it.set_year  = 12'($urandom);
        it.day_count = 16'($urandom);
        if ($urandom_range(99) < 45) begin
            it.func = FUNC_ADV;
            pick = $urandom_range(99);
            if (pick < 60) begin
                it.day_count = 16'($urandom_range(3));
            end else if (pick < 90) begin
                it.day_count = 16'($urandom_range(40));
            end else if (pick < 99) begin
                it.day_count = 16'($urandom_range(400));
            end else begin
                it.day_count = 16'($urandom_range(1000));
            end
        end else begin
            it.func = FUNC_SET;
            if ($urandom_range(99) < 75) begin
                it.set_month = 4'($urandom_range(MONTH_DEC, MONTH_JAN));
                case ($urandom_range(4))
                    0:       it.set_year = YEAR_MIN;
                    1:       it.set_year = YEAR_MAX;
                    2:       it.set_year = 12'(1904 + 4 * $urandom_range(49));
                    default: it.set_year = 12'($urandom_range(YEAR_MAX, YEAR_MIN));
                endcase
                if ($urandom_range(1) == 0) begin
                    it.set_day = 5'(month_days(it.set_month, it.set_year));
                end else begin
                    it.set_day = 5'($urandom_range(month_days(it.set_month, it.set_year), 1));
                end
            end
        end
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item guess;
        while ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        guess = predict_date(it);
        date_expect_q.push_back(typed ? want : guess);
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] date result mismatch on %s: got %0d, expected %0d", $realtime, what,
                 got, want);
        err_count++;
    endtask

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (date_expect_q.size() == 0) begin
                report_mismatch("unexpected transfer", 1, 0);
            end else begin
                want = date_expect_q.pop_front();
                if (out_ch.data.cur_month !== want.cur_month) begin
                    report_mismatch("cur_month", out_ch.data.cur_month, want.cur_month);
                end
                if (out_ch.data.cur_day !== want.cur_day) begin
                    report_mismatch("cur_day", out_ch.data.cur_day, want.cur_day);
                end
                if (out_ch.data.cur_year !== want.cur_year) begin
                    report_mismatch("cur_year", out_ch.data.cur_year, want.cur_year);
                end
                if (out_ch.data.status !== want.status) begin
                    report_mismatch("status", out_ch.data.status, want.status);
                end
            end
        end
    end

    initial begin
        t_in_item it;
        int       i;
        int       r;
        int       ph;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (date_rows[i]) begin
            it.func      = date_rows[i].func;
            it.set_month = date_rows[i].month;
            it.set_day   = date_rows[i].day;
            it.set_year  = date_rows[i].year;
            it.day_count = date_rows[i].count;
            for (r = 0; r < date_rows[i].reps; r++) begin
                push_item(it, date_rows[i].typed, date_rows[i].want);
            end
        end

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    in_idle_pct  = 11;
                    out_idle_pct = 64;
                end
                1: begin
                    in_idle_pct  = 64;
                    out_idle_pct = 11;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            for (i = 0; i < 267; i++) begin
                push_item(random_item(), 1'b0, '0);
            end
        end
        in_ch.valid <= 1'b0;

        while (date_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
